FILE: rtl/xl_pkg.sv
// Shared constants, codes and types for the cross-correlation lag search.
`timescale 1ns / 1ps
package xl_pkg;
    localparam int DEF_MAX_REF_LEN = 4096;
    localparam int DEF_MAX_SHIFT   = 512;

    localparam int SAMP_W    = 16;
    localparam int DOT_W     = 44;
    localparam int ENG_W     = 43;
    localparam int LAG_W     = 11;
    localparam int Q_W       = 16;
    localparam int CMD_W     = 2;
    localparam int IDX_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int RL_W      = 13;
    localparam int MS_W      = 10;
    // wide product for E*W*t^2 and D^2 << 32
    localparam int PROD_W    = 2 * ENG_W + 32;
    localparam int Q15_ONE   = 32768;
    localparam int Q15_MAX   = 32767;

    localparam logic [CMD_W-1:0] CMD_LOAD_REF  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_TEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_REF_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SHIFT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO     = 2'd2;

    localparam logic [RL_W-1:0] RL_RESET = 13'd4096;
    localparam logic [MS_W-1:0] MS_RESET = 10'd1;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_flags;
endpackage

FILE: rtl/xcorr_lag_search.sv
// Top level: command port, configuration registers and the lag search sequencer.
// Load requests never raise busy.
// A start request walks every lag: memory reads and accumulation per lag, plus a
// correlation (twice per lag in stereo, once at the end in mono) and a bitwise
// square-root search at the end in stereo.
// The result shows on o_result_valid for one cycle, in the same cycle busy drops; the
// receiver cannot stall.
// Synchronous active-low reset restores register defaults; sample memories are not cleared.
`timescale 1ns / 1ps
module xcorr_lag_search #(
    parameter int P_MAX_REF_LEN = xl_pkg::DEF_MAX_REF_LEN,
    parameter int P_MAX_SHIFT   = xl_pkg::DEF_MAX_SHIFT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic [xl_pkg::CMD_W-1:0]             i_command,
    input  logic [xl_pkg::IDX_W-1:0]             i_frame_index,
    input  logic signed [xl_pkg::SAMP_W-1:0]     i_sample_left,
    input  logic signed [xl_pkg::SAMP_W-1:0]     i_sample_right,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [xl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [xl_pkg::CFG_DAT_W-1:0]         i_cfg_data,
    output logic                                 o_result_valid,
    output logic signed [xl_pkg::LAG_W-1:0]      o_best_lag,
    output logic signed [xl_pkg::Q_W-1:0]        o_similarity,
    output logic [xl_pkg::ENG_W-1:0]             o_ref_energy
);
    localparam int RA_W = $clog2(P_MAX_REF_LEN);
    localparam int TA_W = $clog2(P_MAX_REF_LEN + 2 * P_MAX_SHIFT);
    localparam int N_W  = $clog2(P_MAX_REF_LEN + 1);
    localparam int S_W  = $clog2(P_MAX_SHIFT + 1);
    localparam int L_W  = $clog2(2 * P_MAX_SHIFT + 1);
    localparam int EW   = xl_pkg::ENG_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ISSUE = 4'd1;
    localparam logic [3:0] S_DRAIN = 4'd2;
    localparam logic [3:0] S_EVAL  = 4'd3;
    localparam logic [3:0] S_CL    = 4'd4;
    localparam logic [3:0] S_CR    = 4'd5;
    localparam logic [3:0] S_SCORE = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_FWAIT = 4'd8;
    localparam logic [3:0] S_SQRT  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    logic [3:0]                r_state;
    logic [xl_pkg::RL_W-1:0]   r_ref_length;
    logic [xl_pkg::MS_W-1:0]   r_max_shift;
    logic                      r_stereo, r_stereo_run;
    logic [N_W-1:0]            r_n1, r_k;
    logic [S_W-1:0]            r_ms;
    logic [L_W-1:0]            r_nlag, r_lag, r_best;
    logic [EW-1:0]             r_top;
    logic signed [xl_pkg::DOT_W-1:0] r_best_dot, r_cdot;
    logic [EW-1:0]             r_best_win, r_ce, r_cw;
    logic signed [xl_pkg::Q_W-1:0] r_cl, r_cr;
    logic                      r_cstart;
    logic [15:0]               r_lo;
    logic [3:0]                r_bit;
    xl_pkg::t_mac_flags        r_fl1;

    logic                      w_accept, w_wr_ref, w_wr_test, w_last_lag;
    logic [N_W-1:0]            w_n1;
    logic [S_W-1:0]            w_ms;
    xl_pkg::t_mac_flags        n_fl0;
    logic signed [xl_pkg::SAMP_W-1:0] w_ref_l, w_ref_r, w_test_l, w_test_r;
    logic                      w_mac_done, w_corr_done;
    logic signed [xl_pkg::DOT_W-1:0] w_dot_l, w_dot_r;
    logic [EW-1:0]             w_win_l, w_win_r, w_en_l, w_en_r, w_mag;
    logic signed [xl_pkg::Q_W-1:0] w_q;
    logic signed [31:0]        w_sq_l, w_sq_r;
    logic [31:0]               w_s;
    logic [15:0]               w_cand;
    logic [16:0]               w_t;
    logic [33:0]               w_tt;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = !o_busy;
    assign w_accept    = i_start && !o_busy;
    assign w_wr_ref    = w_accept && i_command == xl_pkg::CMD_LOAD_REF
                         && 32'(i_frame_index) < 32'(P_MAX_REF_LEN);
    assign w_wr_test   = w_accept && i_command == xl_pkg::CMD_LOAD_TEST
                         && 32'(i_frame_index) < 32'(P_MAX_REF_LEN + 2 * P_MAX_SHIFT);

    // clamp registers into the supported range
    assign w_n1 = (r_ref_length == '0) ? N_W'(1) :
                  (32'(r_ref_length) > 32'(P_MAX_REF_LEN)) ? N_W'(P_MAX_REF_LEN) :
                  N_W'(r_ref_length);
    assign w_ms = (r_max_shift == '0) ? S_W'(1) :
                  (32'(r_max_shift) > 32'(P_MAX_SHIFT)) ? S_W'(P_MAX_SHIFT) :
                  S_W'(r_max_shift);

    assign n_fl0.valid = (r_state == S_ISSUE);
    assign n_fl0.first = (r_k == '0);
    assign n_fl0.last  = (r_k == r_n1 - 1'b1);
    assign w_last_lag  = (r_lag == r_nlag - 1'b1);

    assign w_mag  = EW'(w_dot_l[xl_pkg::DOT_W-1] ? -w_dot_l : w_dot_l);
    assign w_sq_l = r_cl * r_cl;
    assign w_sq_r = r_cr * r_cr;
    assign w_s    = $unsigned(w_sq_l) + $unsigned(w_sq_r);

    assign w_cand = r_lo | (16'd1 << r_bit);
    assign w_t    = {w_cand, 1'b0} - 17'd1;
    assign w_tt   = w_t * w_t;

    xl_store #(
        .MAX_REF_LEN (P_MAX_REF_LEN),
        .MAX_SHIFT   (P_MAX_SHIFT)
    ) u_store (
        .i_clk        (i_clk),
        .i_wr_ref     (w_wr_ref),
        .i_wr_test    (w_wr_test),
        .i_ref_waddr  (RA_W'(i_frame_index)),
        .i_test_waddr (TA_W'(i_frame_index)),
        .i_wdata_l    (i_sample_left),
        .i_wdata_r    (i_sample_right),
        .i_ref_raddr  (r_k[RA_W-1:0]),
        .i_test_raddr (TA_W'(r_lag) + TA_W'(r_k)),
        .o_ref_l      (w_ref_l),
        .o_ref_r      (w_ref_r),
        .o_test_l     (w_test_l),
        .o_test_r     (w_test_r)
    );

    xl_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_flags  (r_fl1),
        .i_ref_l  (w_ref_l),
        .i_ref_r  (w_ref_r),
        .i_test_l (w_test_l),
        .i_test_r (w_test_r),
        .o_done   (w_mac_done),
        .o_dot_l  (w_dot_l),
        .o_dot_r  (w_dot_r),
        .o_win_l  (w_win_l),
        .o_win_r  (w_win_r),
        .o_en_l   (w_en_l),
        .o_en_r   (w_en_r)
    );

    xl_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cstart),
        .i_dot   (r_cdot),
        .i_e     (r_ce),
        .i_w     (r_cw),
        .o_done  (w_corr_done),
        .o_q     (w_q)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_length <= xl_pkg::RL_RESET;
            r_max_shift  <= xl_pkg::MS_RESET;
            r_stereo     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                xl_pkg::CFG_REF_LENGTH: r_ref_length <= i_cfg_data;
                xl_pkg::CFG_MAX_SHIFT:  r_max_shift  <= i_cfg_data[xl_pkg::MS_W-1:0];
                xl_pkg::CFG_STEREO:     r_stereo     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_fl1          <= '0;
            r_cstart       <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            r_fl1          <= n_fl0;
            r_cstart       <= 1'b0;
            o_result_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_command == xl_pkg::CMD_START) begin
                        r_n1         <= w_n1;
                        r_ms         <= w_ms;
                        r_nlag       <= r_stereo ? L_W'(w_ms) + 1'b1 : L_W'(w_ms) << 1;
                        r_stereo_run <= r_stereo;
                        r_lag        <= '0;
                        r_k          <= '0;
                        r_best       <= '0;
                        r_top        <= '0;
                        r_state      <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_k <= r_k + 1'b1;
                    if (n_fl0.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_mac_done) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_stereo_run) begin
                        r_cdot   <= w_dot_l;
                        r_ce     <= w_en_l;
                        r_cw     <= w_win_l;
                        r_cstart <= 1'b1;
                        r_state  <= S_CL;
                    end else begin
                        // lag zero always seeds the pick so ties keep the earliest
                        if (r_lag == '0 || w_mag > r_top) begin
                            r_top      <= w_mag;
                            r_best     <= r_lag;
                            r_best_dot <= w_dot_l;
                            r_best_win <= w_win_l;
                        end
                        r_k   <= '0;
                        r_lag <= r_lag + 1'b1;
                        r_state <= w_last_lag ? S_FIN : S_ISSUE;
                    end
                end
                S_CL: begin
                    if (w_corr_done) begin
                        r_cl     <= w_q;
                        r_cdot   <= w_dot_r;
                        r_ce     <= w_en_r;
                        r_cw     <= w_win_r;
                        r_cstart <= 1'b1;
                        r_state  <= S_CR;
                    end
                end
                S_CR: begin
                    if (w_corr_done) begin
                        r_cr    <= w_q;
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    if (EW'(w_s) > r_top) begin
                        r_top  <= EW'(w_s);
                        r_best <= r_lag;
                    end
                    r_k   <= '0;
                    r_lag <= r_lag + 1'b1;
                    if (w_last_lag) begin
                        r_lo    <= '0;
                        r_bit   <= 4'd15;
                        r_state <= S_SQRT;
                    end else begin
                        r_state <= S_ISSUE;
                    end
                end
                S_FIN: begin
                    r_cdot   <= r_best_dot;
                    r_ce     <= w_en_l;
                    r_cw     <= r_best_win;
                    r_cstart <= 1'b1;
                    r_state  <= S_FWAIT;
                end
                S_FWAIT: begin
                    if (w_corr_done) begin
                        o_similarity <= w_q;
                        o_ref_energy <= w_en_l;
                        r_state      <= S_OUT;
                    end
                end
                S_SQRT: begin
                    // bitwise search for round(sqrt(top/2)) on 2*top
                    if (17'(w_cand) <= 17'(xl_pkg::Q15_ONE)
                        && w_tt <= (34'(r_top) << 1)) begin
                        r_lo <= w_cand;
                    end
                    if (r_bit == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_bit <= r_bit - 1'b1;
                    end
                end
                S_OUT: begin
                    if (r_stereo_run) begin
                        o_similarity <= (17'(r_lo) > 17'(xl_pkg::Q15_MAX))
                                        ? xl_pkg::Q_W'(xl_pkg::Q15_MAX) : $signed(r_lo);
                        o_ref_energy <= EW'(({1'b0, w_en_l} + {1'b0, w_en_r}) >> 1);
                    end
                    o_best_lag     <= xl_pkg::LAG_W'(r_best) - xl_pkg::LAG_W'(r_ms);
                    o_result_valid <= 1'b1;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_busy_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start) && $past(i_command) == xl_pkg::CMD_START)
        else $error("search began without a start request");

    a_result_ends_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !o_busy && $past(o_busy))
        else $error("result outside a search");

    a_stereo_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && r_stereo_run |-> !o_similarity[xl_pkg::Q_W-1])
        else $error("negative stereo similarity");
endmodule

FILE: rtl/xl_store.sv
// Reference and test sample memories, one write port and one registered read port each.
`timescale 1ns / 1ps
module xl_store #(
    parameter int MAX_REF_LEN = xl_pkg::DEF_MAX_REF_LEN,
    parameter int MAX_SHIFT   = xl_pkg::DEF_MAX_SHIFT,
    localparam int RA_W = $clog2(MAX_REF_LEN),
    localparam int TA_W = $clog2(MAX_REF_LEN + 2 * MAX_SHIFT)
) (
    input  logic                              i_clk,
    input  logic                              i_wr_ref,
    input  logic                              i_wr_test,
    input  logic [RA_W-1:0]                   i_ref_waddr,
    input  logic [TA_W-1:0]                   i_test_waddr,
    input  logic signed [xl_pkg::SAMP_W-1:0]  i_wdata_l,
    input  logic signed [xl_pkg::SAMP_W-1:0]  i_wdata_r,
    input  logic [RA_W-1:0]                   i_ref_raddr,
    input  logic [TA_W-1:0]                   i_test_raddr,
    output logic signed [xl_pkg::SAMP_W-1:0]  o_ref_l,
    output logic signed [xl_pkg::SAMP_W-1:0]  o_ref_r,
    output logic signed [xl_pkg::SAMP_W-1:0]  o_test_l,
    output logic signed [xl_pkg::SAMP_W-1:0]  o_test_r
);
    localparam int TEST_DEPTH = MAX_REF_LEN + 2 * MAX_SHIFT;

    logic signed [xl_pkg::SAMP_W-1:0] r_ref_l_mem  [MAX_REF_LEN];
    logic signed [xl_pkg::SAMP_W-1:0] r_ref_r_mem  [MAX_REF_LEN];
    logic signed [xl_pkg::SAMP_W-1:0] r_test_l_mem [TEST_DEPTH];
    logic signed [xl_pkg::SAMP_W-1:0] r_test_r_mem [TEST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_ref) begin
            r_ref_l_mem[i_ref_waddr] <= i_wdata_l;
            r_ref_r_mem[i_ref_waddr] <= i_wdata_r;
        end
        o_ref_l <= r_ref_l_mem[i_ref_raddr];
        o_ref_r <= r_ref_r_mem[i_ref_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_test) begin
            r_test_l_mem[i_test_waddr] <= i_wdata_l;
            r_test_r_mem[i_test_waddr] <= i_wdata_r;
        end
        o_test_l <= r_test_l_mem[i_test_raddr];
        o_test_r <= r_test_r_mem[i_test_raddr];
    end
endmodule

FILE: rtl/xl_mac.sv
// Per-lag multiply-accumulate: dot products, window energies and reference energies.
`timescale 1ns / 1ps
module xl_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  xl_pkg::t_mac_flags                i_flags,
    input  logic signed [xl_pkg::SAMP_W-1:0]  i_ref_l,
    input  logic signed [xl_pkg::SAMP_W-1:0]  i_ref_r,
    input  logic signed [xl_pkg::SAMP_W-1:0]  i_test_l,
    input  logic signed [xl_pkg::SAMP_W-1:0]  i_test_r,
    output logic                              o_done,
    output logic signed [xl_pkg::DOT_W-1:0]   o_dot_l,
    output logic signed [xl_pkg::DOT_W-1:0]   o_dot_r,
    output logic [xl_pkg::ENG_W-1:0]          o_win_l,
    output logic [xl_pkg::ENG_W-1:0]          o_win_r,
    output logic [xl_pkg::ENG_W-1:0]          o_en_l,
    output logic [xl_pkg::ENG_W-1:0]          o_en_r
);
    localparam int PW = 2 * xl_pkg::SAMP_W;

    xl_pkg::t_mac_flags r_pf;
    logic signed [PW-1:0] r_pd_l, r_pd_r, r_sw_l, r_sw_r, r_se_l, r_se_r;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pf <= '0;
        end else begin
            r_pf <= i_flags;
        end
        r_pd_l <= i_ref_l * i_test_l;
        r_pd_r <= i_ref_r * i_test_r;
        r_sw_l <= i_test_l * i_test_l;
        r_sw_r <= i_test_r * i_test_r;
        r_se_l <= i_ref_l * i_ref_l;
        r_se_r <= i_ref_r * i_ref_r;
    end

    // accumulate stage; first term restarts the sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_pf.valid && r_pf.last;
        end
        if (r_pf.valid) begin
            if (r_pf.first) begin
                o_dot_l <= xl_pkg::DOT_W'(r_pd_l);
                o_dot_r <= xl_pkg::DOT_W'(r_pd_r);
                o_win_l <= xl_pkg::ENG_W'($unsigned(r_sw_l));
                o_win_r <= xl_pkg::ENG_W'($unsigned(r_sw_r));
                o_en_l  <= xl_pkg::ENG_W'($unsigned(r_se_l));
                o_en_r  <= xl_pkg::ENG_W'($unsigned(r_se_r));
            end else begin
                o_dot_l <= o_dot_l + xl_pkg::DOT_W'(r_pd_l);
                o_dot_r <= o_dot_r + xl_pkg::DOT_W'(r_pd_r);
                o_win_l <= o_win_l + xl_pkg::ENG_W'($unsigned(r_sw_l));
                o_win_r <= o_win_r + xl_pkg::ENG_W'($unsigned(r_sw_r));
                o_en_l  <= o_en_l + xl_pkg::ENG_W'($unsigned(r_se_l));
                o_en_r  <= o_en_r + xl_pkg::ENG_W'($unsigned(r_se_r));
            end
        end
    end
endmodule

FILE: rtl/xl_corr.sv
// Normalized correlation in Q1.15: shift-add multiplier plus bitwise search for the quotient.
`timescale 1ns / 1ps
module xl_corr (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [xl_pkg::DOT_W-1:0]  i_dot,
    input  logic [xl_pkg::ENG_W-1:0]         i_e,
    input  logic [xl_pkg::ENG_W-1:0]         i_w,
    output logic                             o_done,
    output logic signed [xl_pkg::Q_W-1:0]    o_q
);
    localparam int PW  = xl_pkg::PROD_W;
    localparam int EW  = xl_pkg::ENG_W;
    localparam int C_W = $clog2(EW);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MP   = 3'd1;
    localparam logic [2:0] C_MD   = 3'd2;
    localparam logic [2:0] C_TT   = 3'd3;
    localparam logic [2:0] C_MT   = 3'd4;
    localparam logic [2:0] C_CMP  = 3'd5;
    localparam logic [2:0] C_DONE = 3'd6;

    logic [2:0]    r_state;
    logic          r_neg;
    logic [EW-1:0] r_mag;
    logic [PW-1:0] r_p, r_rhs, r_ma, r_macc;
    logic [EW-1:0] r_mb;
    logic [C_W-1:0] r_cnt;
    logic [15:0]   r_lo, r_cand;
    logic [3:0]    r_bit;

    logic [PW-1:0] n_macc;
    logic          w_last;
    logic [15:0]   w_cand;
    logic [16:0]   w_t;
    logic [33:0]   w_tt;

    assign n_macc = r_mb[0] ? r_macc + r_ma : r_macc;
    assign w_last = (r_cnt == C_W'(EW - 1));
    assign w_cand = r_lo | (16'd1 << r_bit);
    assign w_t    = {w_cand, 1'b0} - 17'd1;
    assign w_tt   = w_t * w_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        if (i_e == '0 || i_w == '0) begin
                            o_q    <= xl_pkg::Q_W'(xl_pkg::Q15_MAX);
                            o_done <= 1'b1;
                        end else begin
                            r_neg   <= i_dot[xl_pkg::DOT_W-1];
                            r_mag   <= EW'(i_dot[xl_pkg::DOT_W-1] ? -i_dot : i_dot);
                            r_ma    <= PW'(i_e);
                            r_mb    <= i_w;
                            r_macc  <= '0;
                            r_cnt   <= '0;
                            r_state <= C_MP;
                        end
                    end
                end
                C_MP, C_MD, C_MT: begin
                    r_macc <= n_macc;
                    r_ma   <= r_ma << 1;
                    r_mb   <= r_mb >> 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (w_last) begin
                        if (r_state == C_MP) begin
                            r_p     <= n_macc;
                            r_ma    <= PW'(r_mag);
                            r_mb    <= r_mag;
                            r_macc  <= '0;
                            r_cnt   <= '0;
                            r_state <= C_MD;
                        end else if (r_state == C_MD) begin
                            r_rhs   <= n_macc << 32;
                            r_lo    <= '0;
                            r_bit   <= 4'd15;
                            r_state <= C_TT;
                        end else begin
                            r_state <= C_CMP;
                        end
                    end
                end
                C_TT: begin
                    if (17'(w_cand) > 17'(xl_pkg::Q15_ONE)) begin
                        if (r_bit == '0) begin
                            r_state <= C_DONE;
                        end else begin
                            r_bit <= r_bit - 1'b1;
                        end
                    end else begin
                        r_cand  <= w_cand;
                        r_ma    <= r_p;
                        r_mb    <= EW'(w_tt);
                        r_macc  <= '0;
                        r_cnt   <= '0;
                        r_state <= C_MT;
                    end
                end
                C_CMP: begin
                    if (r_macc <= r_rhs) begin
                        r_lo <= r_cand;
                    end
                    if (r_bit == '0) begin
                        r_state <= C_DONE;
                    end else begin
                        r_bit   <= r_bit - 1'b1;
                        r_state <= C_TT;
                    end
                end
                C_DONE: begin
                    if (r_neg) begin
                        o_q <= $signed(~r_lo + 16'd1);
                    end else if (17'(r_lo) > 17'(xl_pkg::Q15_MAX)) begin
                        o_q <= xl_pkg::Q_W'(xl_pkg::Q15_MAX);
                    end else begin
                        o_q <= $signed(r_lo);
                    end
                    o_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end
endmodule

FILE: test/tb_xcorr_lag_search.sv
// Self-checking testbench for the cross-correlation lag search block.
`timescale 1ns / 1ps
module tb_xcorr_lag_search;
    localparam int REF_DEPTH  = xl_pkg::DEF_MAX_REF_LEN;
    localparam int TEST_DEPTH = xl_pkg::DEF_MAX_REF_LEN + 2 * xl_pkg::DEF_MAX_SHIFT;
    localparam int STALL_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 50;
    localparam int ITEM_TARGET = 1350;
    localparam logic [xl_pkg::CMD_W-1:0]     CMD_NONE   = 2'd3;
    localparam logic [xl_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [xl_pkg::CMD_W-1:0]         cmd;
        logic [xl_pkg::IDX_W-1:0]         idx;
        logic signed [xl_pkg::SAMP_W-1:0] left;
        logic signed [xl_pkg::SAMP_W-1:0] right;
    } t_frame_req;

    typedef struct {
        logic signed [xl_pkg::LAG_W-1:0] lag;
        logic signed [xl_pkg::Q_W-1:0]   sim;
        logic [xl_pkg::ENG_W-1:0]        eng;
    } t_lag_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_start = 1'b0;
    logic                             o_busy;
    logic [xl_pkg::CMD_W-1:0]         i_command = '0;
    logic [xl_pkg::IDX_W-1:0]         i_frame_index = '0;
    logic signed [xl_pkg::SAMP_W-1:0] i_sample_left = '0;
    logic signed [xl_pkg::SAMP_W-1:0] i_sample_right = '0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [xl_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [xl_pkg::CFG_DAT_W-1:0]     i_cfg_data = '0;
    logic                             o_result_valid;
    logic signed [xl_pkg::LAG_W-1:0]  o_best_lag;
    logic signed [xl_pkg::Q_W-1:0]    o_similarity;
    logic [xl_pkg::ENG_W-1:0]         o_ref_energy;

    xcorr_lag_search DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow state of the block
    logic signed [xl_pkg::SAMP_W-1:0] ref_l [REF_DEPTH];
    logic signed [xl_pkg::SAMP_W-1:0] ref_r [REF_DEPTH];
    logic signed [xl_pkg::SAMP_W-1:0] test_l [TEST_DEPTH];
    logic signed [xl_pkg::SAMP_W-1:0] test_r [TEST_DEPTH];
    logic [xl_pkg::RL_W-1:0] sh_ref_len = xl_pkg::RL_RESET;
    logic [xl_pkg::MS_W-1:0] sh_max_shift = xl_pkg::MS_RESET;
    logic                    sh_stereo = 1'b0;

    t_frame_req  req_q[$];
    t_lag_result lag_results_q[$];
    t_frame_req  nxt;
    t_lag_result got;
    int err_cnt = 0;
    int cyc = 0;
    int stall_cnt = 0;
    int items_pushed = 0;
    int ref_hw = 0;
    int test_hw = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // round-half-up of 32768*|d|/sqrt(e1*e2), exact in integers
    function automatic logic signed [xl_pkg::Q_W-1:0] corr_q15(input longint d,
            input logic [63:0] e1, input logic [63:0] e2);
        logic [127:0] p, rhs, t, lhs;
        logic [63:0] mag;
        int unsigned lo, hi, mid;
        if (e1 == 0 || e2 == 0) return xl_pkg::Q_W'(xl_pkg::Q15_MAX);
        p = {64'd0, e1} * {64'd0, e2};
        mag = d < 0 ? -d : d;
        rhs = ({64'd0, mag} * {64'd0, mag}) << 32;
        lo = 0;
        hi = xl_pkg::Q15_ONE;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 128'(2 * mid - 1);
            lhs = p * t * t;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (d < 0) return xl_pkg::Q_W'(-int'(lo));
        return xl_pkg::Q_W'(lo > xl_pkg::Q15_MAX ? xl_pkg::Q15_MAX : lo);
    endfunction

    function automatic void lag_terms(input int lag, input int n1, input bit right,
            output longint d, output longint w);
        longint t, r;
        d = 0;
        w = 0;
        for (int k = 0; k < n1; k++) begin
            t = right ? test_r[lag + k] : test_l[lag + k];
            r = right ? ref_r[k] : ref_l[k];
            d += r * t;
            w += t * t;
        end
    endfunction

    function automatic t_lag_result search_lags();
        t_lag_result res;
        int n1, ms, best;
        longint el, er, dl, wl, dr, wr, cl, cr, s, top, s2, t;
        int unsigned lo, hi, mid;
        n1 = sh_ref_len < 1 ? 1 : (sh_ref_len > REF_DEPTH ? REF_DEPTH : sh_ref_len);
        ms = sh_max_shift < 1 ? 1 :
             (sh_max_shift > xl_pkg::DEF_MAX_SHIFT ? xl_pkg::DEF_MAX_SHIFT : sh_max_shift);
        el = 0;
        er = 0;
        for (int k = 0; k < n1; k++) begin
            el += longint'(ref_l[k]) * ref_l[k];
            er += longint'(ref_r[k]) * ref_r[k];
        end
        best = 0;
        top = 0;
        if (!sh_stereo) begin
            for (int i = 0; i < 2 * ms; i++) begin
                lag_terms(i, n1, 1'b0, dl, wl);
                s = dl < 0 ? -dl : dl;
                if (s > top) begin
                    top = s;
                    best = i;
                end
            end
            lag_terms(best, n1, 1'b0, dl, wl);
            res.sim = corr_q15(dl, el, wl);
            res.eng = xl_pkg::ENG_W'(el);
        end else begin
            for (int i = 0; i <= ms; i++) begin
                lag_terms(i, n1, 1'b0, dl, wl);
                lag_terms(i, n1, 1'b1, dr, wr);
                cl = corr_q15(dl, el, wl);
                cr = corr_q15(dr, er, wr);
                s = cl * cl + cr * cr;
                if (s > top) begin
                    top = s;
                    best = i;
                end
            end
            s2 = 2 * top;
            lo = 0;
            hi = xl_pkg::Q15_ONE;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t = 2 * longint'(mid) - 1;
                if (t * t <= s2) lo = mid;
                else hi = mid - 1;
            end
            res.sim = xl_pkg::Q_W'(lo > xl_pkg::Q15_MAX ? xl_pkg::Q15_MAX : lo);
            res.eng = xl_pkg::ENG_W'((el + er) / 2);
        end
        res.lag = xl_pkg::LAG_W'(best - ms);
        return res;
    endfunction

    task automatic apply_request(input logic [xl_pkg::CMD_W-1:0] cmd,
            input logic [xl_pkg::IDX_W-1:0] idx,
            input logic signed [xl_pkg::SAMP_W-1:0] l,
            input logic signed [xl_pkg::SAMP_W-1:0] r);
        case (cmd)
            xl_pkg::CMD_LOAD_REF: begin
                if (idx < REF_DEPTH) begin
                    ref_l[idx] = l;
                    ref_r[idx] = r;
                end
            end
            xl_pkg::CMD_LOAD_TEST: begin
                if (idx < TEST_DEPTH) begin
                    test_l[idx] = l;
                    test_r[idx] = r;
                end
            end
            xl_pkg::CMD_START: lag_results_q.push_back(search_lags());
            default: ;
        endcase
    endtask

    function automatic bit idle_now();
        if (cyc >= 20000 && cyc < 60000) return 1'b0;
        return $urandom_range(0, 99) < 17;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy)
                apply_request(i_command, i_frame_index, i_sample_left, i_sample_right);
            if (!i_start || !o_busy) begin
                if (req_q.size() != 0 && !idle_now()) begin
                    nxt = req_q.pop_front();
                    i_command <= nxt.cmd;
                    i_frame_index <= nxt.idx;
                    i_sample_left <= nxt.left;
                    i_sample_right <= nxt.right;
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (lag_results_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                got = lag_results_q.pop_front();
                if (o_best_lag !== got.lag)
                    report_mismatch($sformatf("best_lag %0d, want %0d", o_best_lag, got.lag));
                if (o_similarity !== got.sim)
                    report_mismatch($sformatf("similarity %0d, want %0d",
                                              o_similarity, got.sim));
                if (o_ref_energy !== got.eng)
                    report_mismatch($sformatf("ref_energy %0d, want %0d",
                                              o_ref_energy, got.eng));
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_result_valid)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT) begin
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_req(input logic [xl_pkg::CMD_W-1:0] cmd, input int idx,
            input logic signed [xl_pkg::SAMP_W-1:0] l,
            input logic signed [xl_pkg::SAMP_W-1:0] r);
        t_frame_req it;
        it.cmd = cmd;
        it.idx = xl_pkg::IDX_W'(idx);
        it.left = l;
        it.right = r;
        req_q.push_back(it);
        items_pushed++;
    endtask

    function automatic logic signed [xl_pkg::SAMP_W-1:0] rnd_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3, 4, 5: return xl_pkg::SAMP_W'($urandom_range(0, 65535));
            default: return xl_pkg::SAMP_W'(int'($urandom_range(0, 511)) - 256);
        endcase
    endfunction

    // ignored commands and loads that fall outside the stores
    task automatic push_noise();
        case ($urandom_range(0, 2))
            0: push_req(CMD_NONE, $urandom_range(0, 8191), rnd_sample(), rnd_sample());
            1: push_req(xl_pkg::CMD_LOAD_REF, $urandom_range(REF_DEPTH, 8191),
                        rnd_sample(), rnd_sample());
            default: push_req(xl_pkg::CMD_LOAD_TEST, $urandom_range(TEST_DEPTH, 8191),
                              rnd_sample(), rnd_sample());
        endcase
    endtask

    // wait until the block is idle and nothing is outstanding
    task automatic settle();
        while (req_q.size() != 0 || i_start || lag_results_q.size() != 0 || o_busy)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [xl_pkg::CFG_IDX_W-1:0] idx, input int data);
        settle();
        i_cfg_index <= idx;
        i_cfg_data <= xl_pkg::CFG_DAT_W'(data);
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            xl_pkg::CFG_REF_LENGTH: sh_ref_len = xl_pkg::RL_W'(data);
            xl_pkg::CFG_MAX_SHIFT:  sh_max_shift = xl_pkg::MS_W'(data);
            xl_pkg::CFG_STEREO:     sh_stereo = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int rl, input int ms, input bit st, input int starts);
        logic signed [xl_pkg::SAMP_W-1:0] gl [REF_DEPTH];
        logic signed [xl_pkg::SAMP_W-1:0] gr [REF_DEPTH];
        int n1, m, nt, sh;
        bit corr, neg, broken;
        write_reg(xl_pkg::CFG_REF_LENGTH, rl);
        write_reg(xl_pkg::CFG_MAX_SHIFT, ms);
        write_reg(xl_pkg::CFG_STEREO, st);
        if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom_range(0, 8191));
        n1 = rl < 1 ? 1 : (rl > REF_DEPTH ? REF_DEPTH : rl);
        m = ms < 1 ? 1 : (ms > xl_pkg::DEF_MAX_SHIFT ? xl_pkg::DEF_MAX_SHIFT : ms);
        nt = n1 + 2 * m - 1;
        corr = $urandom_range(0, 1);
        neg = $urandom_range(0, 3) == 0;
        broken = $urandom_range(0, 4) == 0;
        sh = $urandom_range(0, 2 * m - 1);
        // broken sequences reload only part of an already written range
        for (int k = 0; k < n1; k++) begin
            gl[k] = rnd_sample();
            gr[k] = rnd_sample();
            if (!(broken && k < ref_hw && $urandom_range(0, 9) < 4))
                push_req(xl_pkg::CMD_LOAD_REF, k, gl[k], gr[k]);
            if ($urandom_range(0, 99) < 8) push_noise();
        end
        for (int j = 0; j < nt; j++) begin
            if (broken && j < test_hw && $urandom_range(0, 9) < 4) continue;
            if (corr && j >= sh && j - sh < n1)
                push_req(xl_pkg::CMD_LOAD_TEST, j, neg ? -gl[j - sh] : gl[j - sh],
                         $urandom_range(0, 1) ? gr[j - sh] : rnd_sample());
            else
                push_req(xl_pkg::CMD_LOAD_TEST, j, rnd_sample(), rnd_sample());
            if ($urandom_range(0, 99) < 8) push_noise();
        end
        if (n1 > ref_hw) ref_hw = n1;
        if (nt > test_hw) test_hw = nt;
        repeat (starts)
            push_req(xl_pkg::CMD_START, $urandom_range(0, 8191), rnd_sample(), rnd_sample());
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-scale opposite signals: correlation of minus one, all lags tie
        write_reg(xl_pkg::CFG_REF_LENGTH, 3);
        write_reg(xl_pkg::CFG_MAX_SHIFT, 2);
        write_reg(xl_pkg::CFG_STEREO, 0);
        write_reg(CFG_UNUSED, 8191);
        for (int k = 0; k < 3; k++)
            push_req(xl_pkg::CMD_LOAD_REF, k, 16'sh8000, 16'sh7FFF);
        for (int k = 0; k < 6; k++)
            push_req(xl_pkg::CMD_LOAD_TEST, k, 16'sh7FFF, 16'sh8000);
        push_req(xl_pkg::CMD_START, 0, 16'sh0000, 16'sh0000);
        push_req(CMD_NONE, 8191, 16'shFFFF, 16'shFFFF);
        push_req(xl_pkg::CMD_LOAD_REF, REF_DEPTH, 16'sh0001, 16'sh0001);
        push_req(xl_pkg::CMD_LOAD_TEST, TEST_DEPTH, 16'sh0001, 16'sh0001);
        push_req(xl_pkg::CMD_LOAD_TEST, 8191, 16'sh0001, 16'sh0001);
        push_req(xl_pkg::CMD_START, 8191, 16'shFFFF, 16'shFFFF);
        ref_hw = 3;
        test_hw = 6;

        // zero energy on the left, zero test window, then zero dot products in mono
        write_reg(xl_pkg::CFG_MAX_SHIFT, 1);
        write_reg(xl_pkg::CFG_REF_LENGTH, 2);
        write_reg(xl_pkg::CFG_STEREO, 1);
        for (int k = 0; k < 2; k++)
            push_req(xl_pkg::CMD_LOAD_REF, k, 16'sh0000, 16'sh7FFF);
        for (int k = 0; k < 3; k++)
            push_req(xl_pkg::CMD_LOAD_TEST, k, 16'sh0000, 16'sh8000);
        push_req(xl_pkg::CMD_START, 0, 16'sh0000, 16'sh0000);
        write_reg(xl_pkg::CFG_STEREO, 0);
        push_req(xl_pkg::CMD_START, 0, 16'sh0000, 16'sh0000);

        // register extremes, zero values clamp up to one
        run_phase(0, 3, 1'b0, 1);
        run_phase(4, 0, 1'b0, 1);
        run_phase(5, 16, 1'b1, 1);
        run_phase(1, 40, 1'b0, 1);

        while (items_pushed < ITEM_TARGET) begin
            if ($urandom_range(0, 1))
                run_phase($urandom_range(0, 9) == 0 ? $urandom_range(13, 64)
                                                    : $urandom_range(1, 12),
                          $urandom_range(1, 4), 1'b1, $urandom_range(1, 2));
            else
                run_phase($urandom_range(0, 9) == 0 ? $urandom_range(13, 64)
                                                    : $urandom_range(1, 12),
                          $urandom_range(0, 9) == 0 ? $urandom_range(9, 64)
                                                    : $urandom_range(1, 8),
                          1'b0, $urandom_range(1, 2));
        end

        settle();
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
